FILE: design/accel_step_detector_macros.svh
// Assertion helpers for the step detector. Both sample on clk and are
// held off while rst_n is low.
`ifndef ACCEL_STEP_DETECTOR_MACROS_SVH
`define ACCEL_STEP_DETECTOR_MACROS_SVH

// Same-cycle implication.
`define ASD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/asd_pkg.sv
`timescale 1ns / 1ps

package asd_pkg;

    // Fixed field widths.
    localparam int TIME_W   = 32;
    localparam int HOUR_W   = 5;
    localparam int THR_W    = 32;
    localparam int MS_W     = 16;
    localparam int COUNT_W  = 24;
    localparam int OUT_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_MAX     = 3'd4;

    // Reset values: (1.5 g)^2 and (0.85 g)^2 at 4096 counts per g.
    localparam logic [THR_W-1:0] HIGH_THR_RST     = 32'd37748736;
    localparam logic [THR_W-1:0] LOW_THR_RST      = 32'd12121539;
    localparam logic [MS_W-1:0]  MIN_INTERVAL_RST = 16'd300;
    localparam logic [MS_W-1:0]  PEAK_MIN_RST     = 16'd60;
    localparam logic [MS_W-1:0]  PEAK_MAX_RST     = 16'd700;

    // A gap longer than this always qualifies.
    localparam logic [TIME_W-1:0] PAUSE_ACCEPT_MS = 32'd2500;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 24'hFFFFFF;
    localparam logic [HOUR_W-1:0]  HOUR_NONE      = 5'd31;
    localparam logic [HOUR_W-1:0]  HOUR_MIDNIGHT  = 5'd0;

    typedef struct packed {
        logic [THR_W-1:0] high_thr;
        logic [THR_W-1:0] low_thr;
        logic [MS_W-1:0]  min_interval;
        logic [MS_W-1:0]  peak_min;
        logic [MS_W-1:0]  peak_max;
    } cfg_t;

    // One sample after the magnitude has been classified.
    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [HOUR_W-1:0] hour;
        logic              above_high;
        logic              below_low;
    } tick_t;

endpackage

FILE: design/asd_mag.sv
`timescale 1ns / 1ps

module asd_mag
    import asd_pkg::*;
#(
    parameter int ACCEL_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [ACCEL_WIDTH-1:0] accel_x,
    input  logic signed [ACCEL_WIDTH-1:0] accel_y,
    input  logic signed [ACCEL_WIDTH-1:0] accel_z,
    input  logic [TIME_W-1:0]             time_ms,
    input  logic [HOUR_W-1:0]             hour,
    output logic                          tick_valid,
    input  logic                          tick_ready,
    output tick_t                         tick
);

    // A square of a two's complement value never exceeds 2^(2W-2).
    localparam int PROD_W = 2 * ACCEL_WIDTH;
    localparam int SQ_W   = PROD_W - 1;
    localparam int MAG_W  = SQ_W + 2;
    localparam int CMP_W  = (MAG_W > THR_W) ? MAG_W : THR_W;

    logic              sq_valid_reg;
    logic [SQ_W-1:0]   sq_x_reg;
    logic [SQ_W-1:0]   sq_y_reg;
    logic [SQ_W-1:0]   sq_z_reg;
    logic [TIME_W-1:0] sq_time_reg;
    logic [HOUR_W-1:0] sq_hour_reg;
    logic              sq_ready;

    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic signed [PROD_W-1:0] prod_z;

    logic              cmp_valid_reg;
    tick_t             cmp_reg;
    logic              cmp_ready;
    logic [MAG_W-1:0]  mag_sq;
    logic [CMP_W-1:0]  mag_ext;
    logic [CMP_W-1:0]  high_ext;
    logic [CMP_W-1:0]  low_ext;

    // Each stage advances when its own slot is free or being emptied.
    assign cmp_ready = !cmp_valid_reg || tick_ready;
    assign sq_ready  = !sq_valid_reg || cmp_ready;
    assign in_ready  = sq_ready;

    // Square stage: one multiplier per axis.
    assign prod_x = PROD_W'(accel_x) * PROD_W'(accel_x);
    assign prod_y = PROD_W'(accel_y) * PROD_W'(accel_y);
    assign prod_z = PROD_W'(accel_z) * PROD_W'(accel_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (sq_ready)
        begin
            sq_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_ready && in_valid)
        begin
            sq_x_reg    <= prod_x[SQ_W-1:0];
            sq_y_reg    <= prod_y[SQ_W-1:0];
            sq_z_reg    <= prod_z[SQ_W-1:0];
            sq_time_reg <= time_ms;
            sq_hour_reg <= hour;
        end
    end

    // Compare stage: sum of squares against both thresholds.
    assign mag_sq   = {2'b00, sq_x_reg} + {2'b00, sq_y_reg} + {2'b00, sq_z_reg};
    assign mag_ext  = CMP_W'(mag_sq);
    assign high_ext = CMP_W'(cfg.high_thr);
    assign low_ext  = CMP_W'(cfg.low_thr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
        end
        else if (cmp_ready)
        begin
            cmp_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_ready && sq_valid_reg)
        begin
            cmp_reg.time_ms    <= sq_time_reg;
            cmp_reg.hour       <= sq_hour_reg;
            cmp_reg.above_high <= (mag_ext > high_ext);
            cmp_reg.below_low  <= (mag_ext < low_ext);
        end
    end

    assign tick_valid = cmp_valid_reg;
    assign tick       = cmp_reg;

endmodule

FILE: design/asd_track.sv
`timescale 1ns / 1ps

module asd_track
    import asd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               tick_valid,
    output logic               tick_ready,
    input  tick_t              tick,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COUNT_W-1:0] out_count,
    output logic               out_taken,
    output logic               out_peak
);

    // Detector state.
    logic               armed_reg;
    logic [TIME_W-1:0]  start_reg;
    logic [TIME_W-1:0]  last_step_reg;
    logic               seen_reg;
    logic [HOUR_W-1:0]  prev_hour_reg;
    logic [COUNT_W-1:0] total_reg;

    logic               armed_next;
    logic [TIME_W-1:0]  start_next;
    logic [TIME_W-1:0]  last_step_next;
    logic               seen_next;
    logic [COUNT_W-1:0] total_next;

    // Result register.
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_taken_reg;
    logic               out_peak_reg;

    logic               accept;
    logic               midnight;
    logic [COUNT_W-1:0] total_clr;
    logic               arm;
    logic               armed_mid;
    logic               peak_end;
    logic [TIME_W-1:0]  dur;
    logic [TIME_W-1:0]  gap;
    logic               peak_ok;
    logic               gap_ok;
    logic               taken;

    assign tick_ready = !out_valid_reg || out_ready;
    assign accept     = tick_valid && tick_ready;

    // Midnight clear, then arming, then the end-of-peak test.
    always_comb
    begin
        midnight  = (tick.hour == HOUR_MIDNIGHT) && (prev_hour_reg != HOUR_MIDNIGHT);
        total_clr = midnight ? '0 : total_reg;

        arm        = !armed_reg && tick.above_high;
        armed_mid  = armed_reg || arm;
        start_next = arm ? tick.time_ms : start_reg;

        // Durations and gaps wrap modulo 2^32.
        peak_end = armed_mid && tick.below_low;
        dur      = tick.time_ms - start_next;
        gap      = tick.time_ms - last_step_reg;
        peak_ok  = (dur >= TIME_W'(cfg.peak_min)) && (dur <= TIME_W'(cfg.peak_max));
        gap_ok   = !seen_reg || (gap > PAUSE_ACCEPT_MS) ||
                   (gap >= TIME_W'(cfg.min_interval));
        taken    = peak_end && peak_ok && gap_ok;

        armed_next     = armed_mid && !peak_end;
        last_step_next = taken ? tick.time_ms : last_step_reg;
        seen_next      = seen_reg || taken;
        total_next     = (taken && (total_clr != COUNT_MAX)) ?
                         total_clr + COUNT_W'(1) : total_clr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            start_reg     <= '0;
            last_step_reg <= '0;
            seen_reg      <= 1'b0;
            prev_hour_reg <= HOUR_NONE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                armed_reg     <= armed_next;
                start_reg     <= start_next;
                last_step_reg <= last_step_next;
                seen_reg      <= seen_next;
                prev_hour_reg <= tick.hour;
                total_reg     <= total_next;
            end
            if (tick_ready)
            begin
                out_valid_reg <= tick_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_count_reg <= total_next;
            out_taken_reg <= taken;
            out_peak_reg  <= armed_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;
    assign out_taken = out_taken_reg;
    assign out_peak  = out_peak_reg;

endmodule

FILE: design/accel_step_detector.sv
`timescale 1ns / 1ps
// Accelerometer step counter.
// Input words arrive on the s_axis channel, one sample each: x, y and z
// acceleration, a millisecond timestamp and the hour of day. Every input
// word yields exactly one output word on the m_axis channel carrying the
// running step count, a flag for a step completed by this sample and the
// armed state of the peak detector.
// The path has four register stages: input register, squaring, magnitude
// compare, and state update with the output register. Words pass them in
// that order; while the receiver takes words, one word can be accepted
// every cycle, and the state update closes its loop in the last stage.
// Each stage moves on when the stage after it is empty or being drained,
// so a stalled receiver fills the stages one by one and s_axis_tready
// drops only when all of them hold a word.
// Reset clears the pipeline, the detector state and the count, and loads
// the default thresholds and time limits. The user must write the
// threshold registers through cfg_wr_en, cfg_index and cfg_data while
// no word is in flight; the block itself does not enforce this.
`include "accel_step_detector_macros.svh"

module accel_step_detector
    import asd_pkg::*;
#(
    parameter int ACCEL_WIDTH = 16
)
(
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               s_axis_tvalid,
    output logic                                               s_axis_tready,
    // accel_x, accel_y, accel_z, time_ms, hour_of_day, then zero fill
    input  logic [((3*ACCEL_WIDTH+TIME_W+HOUR_W+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                               m_axis_tvalid,
    input  logic                                               m_axis_tready,
    // step_count, step_taken, peak_active, then zero fill
    output logic [OUT_W-1:0]                                   m_axis_tdata,
    input  logic                                               cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                               cfg_index,
    input  logic [THR_W-1:0]                                   cfg_data
);

    localparam int X_LO    = 0;
    localparam int Y_LO    = ACCEL_WIDTH;
    localparam int Z_LO    = 2 * ACCEL_WIDTH;
    localparam int TIME_LO = 3 * ACCEL_WIDTH;
    localparam int HOUR_LO = TIME_LO + TIME_W;
    localparam int PAD_W   = OUT_W - COUNT_W - 2;

    cfg_t cfg_reg;

    logic                          in_valid_reg;
    logic signed [ACCEL_WIDTH-1:0] in_x_reg;
    logic signed [ACCEL_WIDTH-1:0] in_y_reg;
    logic signed [ACCEL_WIDTH-1:0] in_z_reg;
    logic [TIME_W-1:0]             in_time_reg;
    logic [HOUR_W-1:0]             in_hour_reg;
    logic                          mag_ready;

    logic               tick_valid;
    logic               tick_ready;
    tick_t              tick;
    logic [COUNT_W-1:0] step_count;
    logic               step_taken;
    logic               peak_active;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_thr     <= HIGH_THR_RST;
            cfg_reg.low_thr      <= LOW_THR_RST;
            cfg_reg.min_interval <= MIN_INTERVAL_RST;
            cfg_reg.peak_min     <= PEAK_MIN_RST;
            cfg_reg.peak_max     <= PEAK_MAX_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_HIGH_THR:     cfg_reg.high_thr     <= cfg_data;
                REG_LOW_THR:      cfg_reg.low_thr      <= cfg_data;
                REG_MIN_INTERVAL: cfg_reg.min_interval <= cfg_data[MS_W-1:0];
                REG_PEAK_MIN:     cfg_reg.peak_min     <= cfg_data[MS_W-1:0];
                REG_PEAK_MAX:     cfg_reg.peak_max     <= cfg_data[MS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input register.
    assign s_axis_tready = !in_valid_reg || mag_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_x_reg    <= s_axis_tdata[X_LO +: ACCEL_WIDTH];
            in_y_reg    <= s_axis_tdata[Y_LO +: ACCEL_WIDTH];
            in_z_reg    <= s_axis_tdata[Z_LO +: ACCEL_WIDTH];
            in_time_reg <= s_axis_tdata[TIME_LO +: TIME_W];
            in_hour_reg <= s_axis_tdata[HOUR_LO +: HOUR_W];
        end
    end

    // Squared magnitude and threshold classification.
    asd_mag #(
        .ACCEL_WIDTH (ACCEL_WIDTH)
    ) u_mag (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid_reg),
        .in_ready   (mag_ready),
        .accel_x    (in_x_reg),
        .accel_y    (in_y_reg),
        .accel_z    (in_z_reg),
        .time_ms    (in_time_reg),
        .hour       (in_hour_reg),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick)
    );

    // Peak tracking, step counting and the output register.
    asd_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_count  (step_count),
        .out_taken  (step_taken),
        .out_peak   (peak_active)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, peak_active, step_taken, step_count};

    // A completed step always disarms the peak.
    `ASD_ASSERT_IMPLY(a_step_disarms, m_axis_tvalid && step_taken, !peak_active,
        "step reported while the peak is still armed")

    // A counted step leaves a nonzero count, even when saturated.
    `ASD_ASSERT_IMPLY(a_step_counts, m_axis_tvalid && step_taken, step_count != '0,
        "step reported with a zero count")

    // The input can only stall behind a held output word.
    `ASD_ASSERT_IMPLY(a_stall_source, !s_axis_tready, m_axis_tvalid && !m_axis_tready,
        "input stalled while the output side is free")

endmodule

FILE: bench/accel_step_detector_tb.sv
`timescale 1ns / 1ps

module accel_step_detector_tb
    import asd_pkg::*;
();

    localparam int ACCEL_W = 16;
    localparam int IN_W    = ((3*ACCEL_W + TIME_W + HOUR_W + 7) / 8) * 8;
    localparam int FILL_W  = IN_W - 3*ACCEL_W - TIME_W - HOUR_W;

    // Index past the register list; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum {MAG_BELOW, MAG_BETWEEN, MAG_ABOVE} mag_kind_t;

    typedef struct packed {
        logic signed [ACCEL_W-1:0] ax;
        logic signed [ACCEL_W-1:0] ay;
        logic signed [ACCEL_W-1:0] az;
        logic [TIME_W-1:0]         time_ms;
        logic [HOUR_W-1:0]         hour;
    } sample_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               taken;
        logic               active;
    } step_report_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    // accel_x, accel_y, accel_z, time_ms, hour_of_day, then zero fill
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // step_count, step_taken, peak_active, then zero fill
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THR_W-1:0]  cfg_data;

    // Shadow of the register file and of the detector state.
    cfg_t               cfg_shadow;
    logic               det_armed;
    logic [TIME_W-1:0]  det_peak_start;
    logic [TIME_W-1:0]  det_last_step;
    logic               det_step_seen;
    logic [HOUR_W-1:0]  det_prev_hour;
    logic [COUNT_W-1:0] det_total;

    step_report_t reports_due[$];
    int           mismatch_count = 0;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    logic [TIME_W-1:0] now_ms;
    logic [HOUR_W-1:0] cur_hour;

    accel_step_detector #(.ACCEL_WIDTH(ACCEL_W)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Squared magnitude of one signed axis, exact in 64 bits.
    function automatic logic [63:0] axis_square(logic signed [ACCEL_W-1:0] v);
        longint s;
        s = longint'(v);
        return s * s;
    endfunction

    // Advance the shadow detector by one sample and return its report.
    function automatic step_report_t compute_step_report(sample_t s);
        logic [63:0]       msq;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] gap;
        logic              taken;
        step_report_t      r;
        msq = axis_square(s.ax) + axis_square(s.ay) + axis_square(s.az);
        taken = 1'b0;

        // Midnight clear fires only on the change into hour zero.
        if (s.hour == HOUR_MIDNIGHT && det_prev_hour != HOUR_MIDNIGHT)
            det_total = '0;
        det_prev_hour = s.hour;

        if (!det_armed && msq > cfg_shadow.high_thr)
        begin
            det_armed = 1'b1;
            det_peak_start = s.time_ms;
        end

        // A peak may arm and end in the same sample when high is below low.
        if (det_armed && msq < cfg_shadow.low_thr)
        begin
            dur = s.time_ms - det_peak_start;
            gap = s.time_ms - det_last_step;
            if (dur >= cfg_shadow.peak_min && dur <= cfg_shadow.peak_max &&
                (!det_step_seen || gap > PAUSE_ACCEPT_MS || gap >= cfg_shadow.min_interval))
            begin
                if (det_total < COUNT_MAX)
                    det_total = det_total + 1'b1;
                det_last_step = s.time_ms;
                det_step_seen = 1'b1;
                taken = 1'b1;
            end
            det_armed = 1'b0;
        end

        r.count = det_total;
        r.taken = taken;
        r.active = det_armed;
        return r;
    endfunction

    function automatic logic signed [ACCEL_W-1:0] signed_pick(int unsigned mag);
        logic signed [ACCEL_W-1:0] v;
        v = ACCEL_W'(mag);
        return $urandom_range(1) ? -v : v;
    endfunction

    // Random sample whose magnitude falls in the chosen band. The bands hold
    // for the default thresholds and for every random setting used below.
    function automatic sample_t make_sample(mag_kind_t kind, logic [TIME_W-1:0] t,
                                            logic [HOUR_W-1:0] hr);
        sample_t s;
        logic signed [ACCEL_W-1:0] big;
        case (kind)
            MAG_ABOVE:
            begin
                s.ax = signed_pick($urandom_range(2000));
                s.ay = signed_pick($urandom_range(2000));
                s.az = signed_pick($urandom_range(2000));
                big = signed_pick($urandom_range(32768, 12000));
                case ($urandom_range(2))
                    0:       s.ax = big;
                    1:       s.ay = big;
                    default: s.az = big;
                endcase
            end
            MAG_BETWEEN:
            begin
                s.ax = signed_pick($urandom_range(4500, 3800));
                s.ay = signed_pick($urandom_range(200));
                s.az = signed_pick($urandom_range(200));
            end
            default:
            begin
                s.ax = signed_pick($urandom_range(800));
                s.ay = signed_pick($urandom_range(800));
                s.az = signed_pick($urandom_range(800));
            end
        endcase
        s.time_ms = t;
        s.hour = hr;
        return s;
    endfunction

    function automatic sample_t fixed_sample(int x, int y, int z, logic [TIME_W-1:0] t,
                                             logic [HOUR_W-1:0] hr);
        sample_t s;
        s.ax = ACCEL_W'(x);
        s.ay = ACCEL_W'(y);
        s.az = ACCEL_W'(z);
        s.time_ms = t;
        s.hour = hr;
        return s;
    endfunction

    // Offer one word with random idle cycles ahead of it, and predict its
    // report once the handshake completes.
    task automatic send_sample(sample_t s);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{FILL_W{1'b0}}, s.hour, s.time_ms, s.az, s.ay, s.ax};
        do
            @(posedge clk);
        while (!s_axis_tready);
        reports_due.push_back(compute_step_report(s));
    endtask

    task automatic send_at(mag_kind_t kind, logic [TIME_W-1:0] t);
        now_ms = t;
        send_sample(make_sample(kind, t, cur_hour));
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic drain_words();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_HIGH_THR:     cfg_shadow.high_thr = data;
            REG_LOW_THR:      cfg_shadow.low_thr = data;
            REG_MIN_INTERVAL: cfg_shadow.min_interval = data[MS_W-1:0];
            REG_PEAK_MIN:     cfg_shadow.peak_min = data[MS_W-1:0];
            REG_PEAK_MAX:     cfg_shadow.peak_max = data[MS_W-1:0];
            default:          ;
        endcase
    endtask

    // Axis extremes, time extremes and hours outside the day.
    task automatic test_field_extremes();
        send_sample(fixed_sample(-32768, -32768, -32768, 32'd0, HOUR_MIDNIGHT));
        send_sample(fixed_sample(32767, 32767, 32767, 32'hFFFF_FFFF, 5'd23));
        send_sample(fixed_sample(0, 0, 0, 32'd100, 5'd31));
        send_sample(fixed_sample(-1, 1, -1, 32'd200, 5'd24));
        send_sample(fixed_sample(-32768, 0, 0, 32'd1000, HOUR_MIDNIGHT));
        send_sample(fixed_sample(0, 0, 0, 32'd1060, HOUR_MIDNIGHT));
        cur_hour = HOUR_MIDNIGHT;
    endtask

    // Peak length at and just past both limits, and the step interval limit.
    task automatic test_peak_duration();
        send_at(MAG_ABOVE, 32'd10000);
        send_at(MAG_BELOW, 32'd10059);
        send_at(MAG_ABOVE, 32'd11000);
        send_at(MAG_BELOW, 32'd11060);
        send_at(MAG_ABOVE, 32'd12000);
        send_at(MAG_BELOW, 32'd12700);
        send_at(MAG_ABOVE, 32'd14000);
        send_at(MAG_BELOW, 32'd14701);
        send_at(MAG_ABOVE, 32'd15900);
        send_at(MAG_BELOW, 32'd16000);
        send_at(MAG_ABOVE, 32'd16199);
        send_at(MAG_BELOW, 32'd16299);
        send_at(MAG_ABOVE, 32'd16300);
        send_at(MAG_BELOW, 32'd16400);
    endtask

    // A peak that spans the wrap of the millisecond counter.
    task automatic test_time_wrap();
        send_at(MAG_ABOVE, 32'hFFFF_FFD0);
        send_at(MAG_BELOW, 32'd12);
    endtask

    // Count clears on the change to hour zero, but not while it stays there.
    task automatic test_midnight_clear();
        cur_hour = 5'd23;
        send_at(MAG_ABOVE, 32'd20000);
        send_at(MAG_BELOW, 32'd20100);
        cur_hour = HOUR_MIDNIGHT;
        send_at(MAG_BETWEEN, 32'd20500);
        send_at(MAG_ABOVE, 32'd21000);
        send_at(MAG_BELOW, 32'd21100);
        send_at(MAG_BETWEEN, 32'd21500);
    endtask

    // Register extremes, arm and end in one sample, and the long-pause rule.
    task automatic test_config_extremes();
        drain_words();
        write_config(REG_HIGH_THR, '0);
        write_config(REG_LOW_THR, '0);
        send_sample(fixed_sample(0, 0, 0, 32'd30000, cur_hour));
        send_sample(fixed_sample(1, 0, 0, 32'd30010, cur_hour));

        drain_words();
        write_config(REG_HIGH_THR, '1);
        write_config(REG_LOW_THR, '1);
        send_sample(fixed_sample(-32768, -32768, -32768, 32'd30070, cur_hour));
        send_sample(fixed_sample(-32768, -32768, -32768, 32'd30080, cur_hour));

        drain_words();
        write_config(REG_HIGH_THR, 32'd1000);
        write_config(REG_LOW_THR, 32'd2000000);
        write_config(REG_MIN_INTERVAL, '1);
        write_config(REG_PEAK_MIN, '0);
        write_config(REG_PEAK_MAX, '0);
        send_sample(fixed_sample(1000, 0, 0, 32'd40000, cur_hour));
        send_sample(fixed_sample(0, -1000, 0, 32'd40100, cur_hour));
        send_sample(fixed_sample(0, 0, 1000, 32'd42600, cur_hour));
        send_sample(fixed_sample(-1000, 0, 0, 32'd45100, cur_hour));

        drain_words();
        write_config(REG_UNUSED, '1);
        write_config(REG_HIGH_THR, HIGH_THR_RST);
        write_config(REG_LOW_THR, LOW_THR_RST);
        write_config(REG_PEAK_MIN, '1);
        write_config(REG_PEAK_MAX, '1);
        send_at(MAG_ABOVE, 32'd60000);
        send_at(MAG_BELOW, 32'd60000 + 32'd65535);

        drain_words();
        write_config(REG_MIN_INTERVAL, MIN_INTERVAL_RST);
        write_config(REG_PEAK_MIN, PEAK_MIN_RST);
        write_config(REG_PEAK_MAX, PEAK_MAX_RST);
    endtask

    task automatic send_walk(mag_kind_t kind, int unsigned max_dt);
        int unsigned r;
        if ($urandom_range(99) < 3)
            now_ms += $urandom_range(6000, 2400);
        else
            now_ms += $urandom_range(max_dt);
        r = $urandom_range(99);
        if (r < 4)
            cur_hour = HOUR_W'((cur_hour + 1'b1) % 24);
        else if (r < 6)
            cur_hour = HOUR_W'($urandom_range(31));
        else if (r < 7)
            cur_hour = HOUR_MIDNIGHT;
        send_sample(make_sample(kind, now_ms, cur_hour));
    endtask

    // Mostly well-formed rest/peak/rest walks with random timing, plus noise.
    task automatic test_random_walk(int n_items, int unsigned idle_pct,
                                    int unsigned stall_pct, bit near_wrap);
        int        sent;
        mag_kind_t kind;
        sample_t   s;
        drain_words();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        write_config(REG_HIGH_THR, $urandom_range(140_000_000, 21_000_000));
        write_config(REG_LOW_THR, $urandom_range(14_000_000, 2_000_000));
        write_config(REG_MIN_INTERVAL, $urandom_range(600));
        write_config(REG_PEAK_MIN, $urandom_range(150));
        write_config(REG_PEAK_MAX, $urandom_range(1200, 200));
        if (near_wrap)
            now_ms = 32'hFFFF_FFFF - $urandom_range(20000);
        cur_hour = HOUR_W'($urandom_range(23));
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                s.ax = ACCEL_W'($urandom);
                s.ay = ACCEL_W'($urandom);
                s.az = ACCEL_W'($urandom);
                s.time_ms = $urandom;
                s.hour = HOUR_W'($urandom_range(31));
                send_sample(s);
                sent++;
            end
            else
            begin
                repeat ($urandom_range(3, 1))
                begin
                    kind = MAG_BELOW;
                    if ($urandom_range(1))
                        kind = MAG_BETWEEN;
                    send_walk(kind, 400);
                    sent++;
                end
                repeat ($urandom_range(4, 1))
                begin
                    send_walk(MAG_ABOVE, 150);
                    sent++;
                end
                send_walk(MAG_BELOW, 150);
                sent++;
            end
        end
    endtask

    // Receiver stalls are drawn fresh on every falling edge.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each returned word with the oldest predicted report.
    always @(posedge clk)
    begin : check_reports
        step_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (reports_due.size() == 0)
            begin
                $display("%0t: word %h arrived with no report pending", $time, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = reports_due.pop_front();
                if (m_axis_tdata[COUNT_W-1:0] !== want.count)
                begin
                    $display("%0t: step_count expected %0d got %0d", $time, want.count,
                             m_axis_tdata[COUNT_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[COUNT_W] !== want.taken)
                begin
                    $display("%0t: step_taken expected %b got %b", $time, want.taken,
                             m_axis_tdata[COUNT_W]);
                    mismatch_count++;
                end
                if (m_axis_tdata[COUNT_W+1] !== want.active)
                begin
                    $display("%0t: peak_active expected %b got %b", $time, want.active,
                             m_axis_tdata[COUNT_W+1]);
                    mismatch_count++;
                end
                if (m_axis_tdata[OUT_W-1:COUNT_W+2] !== '0)
                begin
                    $display("%0t: fill bits expected 0 got %h", $time,
                             m_axis_tdata[OUT_W-1:COUNT_W+2]);
                    mismatch_count++;
                end
            end
        end
    end

    // Count saturation needs about 16M steps and is out of reach in a run of
    // this length; the saturating increment is still modeled above.
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 33;
        recv_stall_pct = 77;
        now_ms = '0;
        cur_hour = '0;

        cfg_shadow.high_thr = HIGH_THR_RST;
        cfg_shadow.low_thr = LOW_THR_RST;
        cfg_shadow.min_interval = MIN_INTERVAL_RST;
        cfg_shadow.peak_min = PEAK_MIN_RST;
        cfg_shadow.peak_max = PEAK_MAX_RST;
        det_armed = 1'b0;
        det_peak_start = '0;
        det_last_step = '0;
        det_step_seen = 1'b0;
        det_prev_hour = HOUR_NONE;
        det_total = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_peak_duration();
        test_time_wrap();
        test_midnight_clear();
        test_config_extremes();
        test_random_walk(370, 33, 77, 1'b0);
        test_random_walk(370, 77, 33, 1'b1);
        test_random_walk(370, 0, 0, 1'b0);

        drain_words();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && reports_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/asd_pkg.sv
design/asd_mag.sv
design/asd_track.sv
design/accel_step_detector.sv
bench/accel_step_detector_tb.sv
